@@ rtl/torus_local_density_update_unit_defines.svh @@
// Assertion macros shared by the checker of the density update unit.
`ifndef TORUS_LOCAL_DENSITY_UPDATE_UNIT_DEFINES_SVH
`define TORUS_LOCAL_DENSITY_UPDATE_UNIT_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TLDU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TLDU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/tldu_pkg.sv @@
package tldu_pkg;

   // Grid and number formats.
   localparam int CoordBits  = 8;
   localparam int DimBits    = 9;
   localparam int RadBits    = 3;
   localparam int MarkerBits = 16;
   localparam int AddrBits   = 2 * CoordBits;
   localparam int StoreDepth = 1 << AddrBits;
   localparam int MaxWidth   = 256;
   localparam int MaxHeight  = 256;
   localparam int MaxRadius  = 4;
   localparam int OffBits    = 4;
   localparam int WrapBits   = 11;
   localparam int TermBits   = MarkerBits + 1;
   localparam int SumBits    = 22;
   localparam int RecipBits  = 26;
   localparam int RecipShift = 28;

   // Action codes.
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_RADIUS = 2'd2;

   typedef struct packed {
      logic [1:0]            action;
      logic [CoordBits-1:0]  cell_x;
      logic [CoordBits-1:0]  cell_y;
      logic [MarkerBits-1:0] marker_value;
   } req_type;

   typedef struct packed {
      logic [CoordBits-1:0]  focus_x;
      logic [CoordBits-1:0]  focus_y;
      logic [MarkerBits-1:0] local_density;
      logic                  last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_REDUCE,
      S_WRITE,
      S_RREAD,
      S_RWAIT,
      S_FREAD,
      S_FWAIT,
      S_NBR,
      S_DRAIN,
      S_DIV,
      S_EMIT
   } tldu_state_type;

   // Half height of the disc column at offset d: floor(sqrt(r*r - d*d)).
   function automatic logic [RadBits-1:0] disc_limit(input logic [RadBits-1:0] r,
                                                   input logic signed [OffBits-1:0] d);
      logic [OffBits-1:0] ad;
      logic [RadBits-1:0] res;
      ad = d[OffBits-1] ? OffBits'(-d) : OffBits'(d);
      case ({r, ad[RadBits-1:0]})
         6'o10: res = 3'd1;
         6'o20: res = 3'd2;
         6'o21: res = 3'd1;
         6'o30: res = 3'd3;
         6'o31: res = 3'd2;
         6'o32: res = 3'd2;
         6'o40: res = 3'd4;
         6'o41: res = 3'd3;
         6'o42: res = 3'd3;
         6'o43: res = 3'd2;
         default: res = 3'd0;
      endcase
      if (ad > OffBits'(r)) begin
         res = 3'd0;
      end
      return res;
   endfunction

   // Reciprocal of the disc cell count (5, 13, 29 or 49), rounded up and scaled
   // by 2^RecipShift; exact for every sum below 2^SumBits.
   function automatic logic [RecipBits-1:0] disc_recip(input logic [RadBits-1:0] r);
      logic [RecipBits-1:0] res;
      case (r)
         3'd2: res = 26'd20648882;
         3'd3: res = 26'd9256396;
         3'd4: res = 26'd5478275;
         default: res = 26'd53687092;
      endcase
      return res;
   endfunction

   // Toroidal wrap of a coordinate at most MaxRadius cells outside the grid.
   function automatic logic [CoordBits-1:0] wrap_coord(input logic signed [WrapBits-1:0] v,
                                                      input logic [DimBits-1:0] m);
      logic signed [WrapBits-1:0] t;
      logic signed [WrapBits-1:0] ms;
      t  = v;
      ms = $signed({{(WrapBits-DimBits){1'b0}}, m});
      for (int i = 0; i < MaxRadius; i++) begin
         if (t < 0) begin
            t = t + ms;
         end else if (t >= ms) begin
            t = t - ms;
         end
      end
      return t[CoordBits-1:0];
   endfunction

   // Clipped circular distance term between two markers.
   function automatic logic [TermBits-1:0] clipped_term(input logic [MarkerBits-1:0] a,
                                                       input logic [MarkerBits-1:0] b);
      logic [MarkerBits-1:0] d1;
      logic [MarkerBits-1:0] d2;
      logic [MarkerBits-1:0] d;
      logic [MarkerBits+2:0] five;
      d1   = a - b;
      d2   = b - a;
      d    = (d1 < d2) ? d1 : d2;
      five = {d, 2'b00} + {3'b000, d};
      return (five[MarkerBits+2:MarkerBits] == 3'd0) ? five[TermBits-1:0]
                                                      : TermBits'(1 << MarkerBits);
   endfunction

endpackage

@@ rtl/torus_local_density_update_unit.sv @@
// Local density engine over a toroidal grid of competition markers.
// Items enter on start/req_data and are taken at an edge where start is high
// and busy is low. Action write stores a marker and gives one acknowledgement;
// action read gives one stored density; action update gives one result per
// focus cell of the disc around the named cell, with last set on the final one.
// Results appear on rsp_data for one cycle, marked by rsp_valid; the receiver
// cannot stall them. Configuration goes through csr_valid/csr_index/csr_data
// and is ready only while the block is idle or clearing its density memory.
// Every item with an action other than none first reduces its coordinates
// modulo the grid size. A write or read then finishes. An update then, per
// focus cell, reads its own marker, makes one marker read per disc cell
// (5, 13, 29 or 49), drains the last term, does a reciprocal multiplication
// for the division and stores and emits the result. The single marker memory
// read port sets the cost of an update.
// After reset the density memory is cleared one entry per cycle, with busy
// high; configuration writes are still taken then.
module torus_local_density_update_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  tldu_pkg::req_type          req_data,
   output logic                       rsp_valid,
   output tldu_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [tldu_pkg::DimBits-1:0] csr_data
);

   import tldu_pkg::*;

   tldu_state_type state_ff, state_in;

   logic [DimBits-1:0]          width_ff, height_ff;
   logic [RadBits-1:0]          radius_ff;
   logic [DimBits-1:0]          eff_w, eff_h;
   logic [RadBits-1:0]          eff_r;
   logic [RecipBits-1:0]        recip;

   logic [1:0]                  act_ff;
   logic [MarkerBits-1:0]       mval_ff;
   logic [CoordBits-1:0]        rx_ff, ry_ff;
   logic [2:0]                  bit_ff;
   logic signed [OffBits-1:0]   dx_ff, dy_ff, ex_ff, ey_ff;
   logic [CoordBits-1:0]        fx_ff, fy_ff;
   logic [MarkerBits-1:0]       a_ff;
   logic                        pv_ff, skip_ff;
   logic [SumBits-1:0]          sum_ff, sum_in;
   logic [SumBits-1:0]          quo_ff;
   logic [AddrBits-1:0]         clr_ff;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_ff;

   logic                        accept;
   logic [CoordBits-1:0]        fx, fy, nx, ny;
   logic signed [OffBits-1:0]   rs;
   logic                        focus_last, nbr_last;
   logic signed [OffBits-1:0]   dx_nx, dy_nx, ex_nx, ey_nx;
   logic [15:0]                 wsh, hsh;
   logic [SumBits+RecipBits-1:0] prod;
   logic [TermBits-1:0]         term;

   logic                        mk_we, dn_we;
   logic [AddrBits-1:0]         mk_ra, dn_wa;
   logic [MarkerBits-1:0]       dn_wd, mk_rd, dn_rd;

   // Effective register values, saturated into their legal ranges.
   always_comb begin
      eff_w = (width_ff == '0) ? DimBits'(1)
            : (width_ff > DimBits'(MaxWidth)) ? DimBits'(MaxWidth) : width_ff;
      eff_h = (height_ff == '0) ? DimBits'(1)
            : (height_ff > DimBits'(MaxHeight)) ? DimBits'(MaxHeight) : height_ff;
      eff_r = (radius_ff == '0) ? RadBits'(1)
            : (radius_ff > RadBits'(MaxRadius)) ? RadBits'(MaxRadius) : radius_ff;
      recip = disc_recip(eff_r);
      rs    = $signed({1'b0, eff_r});
   end

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) || (state_ff == S_CLEAR);

   // Focus and neighbour coordinates with wrap-around.
   always_comb begin
      fx = wrap_coord(WrapBits'($signed({1'b0, rx_ff})) + WrapBits'(dx_ff), eff_w);
      fy = wrap_coord(WrapBits'($signed({1'b0, ry_ff})) + WrapBits'(dy_ff), eff_h);
      nx = wrap_coord(WrapBits'($signed({1'b0, fx_ff})) + WrapBits'(ex_ff), eff_w);
      ny = wrap_coord(WrapBits'($signed({1'b0, fy_ff})) + WrapBits'(ey_ff), eff_h);
   end

   // Disc walkers: dx outer, dy inner, both ascending.
   always_comb begin
      focus_last = (dx_ff == rs) && (dy_ff == $signed({1'b0, disc_limit(eff_r, dx_ff)}));
      nbr_last   = (ex_ff == rs) && (ey_ff == $signed({1'b0, disc_limit(eff_r, ex_ff)}));
      if (dy_ff < $signed({1'b0, disc_limit(eff_r, dx_ff)})) begin
         dx_nx = dx_ff;
         dy_nx = dy_ff + OffBits'(1);
      end else begin
         dx_nx = dx_ff + OffBits'(1);
         dy_nx = -$signed({1'b0, disc_limit(eff_r, dx_ff + OffBits'(1))});
      end
      if (ey_ff < $signed({1'b0, disc_limit(eff_r, ex_ff)})) begin
         ex_nx = ex_ff;
         ey_nx = ey_ff + OffBits'(1);
      end else begin
         ex_nx = ex_ff + OffBits'(1);
         ey_nx = -$signed({1'b0, disc_limit(eff_r, ex_ff + OffBits'(1))});
      end
   end

   // Datapath helpers: modulo reduction step, term accumulation, reciprocal product.
   always_comb begin
      wsh    = 16'(eff_w) << bit_ff;
      hsh    = 16'(eff_h) << bit_ff;
      term   = clipped_term(a_ff, mk_rd);
      sum_in = sum_ff + ((pv_ff && !skip_ff) ? SumBits'(term) : '0);
      prod   = (SumBits+RecipBits)'(quo_ff) * (SumBits+RecipBits)'(recip);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (clr_ff == '1) state_in = S_IDLE;
         S_IDLE:   if (start && req_data.action != ACT_NONE) state_in = S_REDUCE;
         S_REDUCE: begin
            if (bit_ff == 3'd0) begin
               unique case (act_ff)
                  ACT_WRITE:  state_in = S_WRITE;
                  ACT_READ:   state_in = S_RREAD;
                  default:    state_in = S_FREAD;
               endcase
            end
         end
         S_WRITE:  state_in = S_IDLE;
         S_RREAD:  state_in = S_RWAIT;
         S_RWAIT:  state_in = S_IDLE;
         S_FREAD:  state_in = S_FWAIT;
         S_FWAIT:  state_in = S_NBR;
         S_NBR:    if (nbr_last) state_in = S_DRAIN;
         S_DRAIN:  state_in = S_DIV;
         S_DIV:    state_in = S_EMIT;
         S_EMIT:   state_in = focus_last ? S_IDLE : S_FREAD;
         default:  state_in = S_IDLE;
      endcase
   end

   // Memory port controls.
   always_comb begin
      mk_we = (state_ff == S_WRITE);
      mk_ra = (state_ff == S_FREAD) ? {fx, fy} : {nx, ny};
      dn_we = (state_ff == S_CLEAR) || (state_ff == S_EMIT);
      dn_wa = (state_ff == S_CLEAR) ? clr_ff : {fx_ff, fy_ff};
      dn_wd = (state_ff == S_CLEAR) ? '0 : quo_ff[MarkerBits-1:0];
   end

   tldu_ram #(.WIDTH(MarkerBits), .DEPTH(StoreDepth)) u_marker_ram (
      .clock   (clock),
      .wr_en   (mk_we),
      .wr_addr ({rx_ff, ry_ff}),
      .wr_data (mval_ff),
      .rd_addr (mk_ra),
      .rd_data (mk_rd)
   );

   tldu_ram #(.WIDTH(MarkerBits), .DEPTH(StoreDepth)) u_density_ram (
      .clock   (clock),
      .wr_en   (dn_we),
      .wr_addr (dn_wa),
      .wr_data (dn_wd),
      .rd_addr ({rx_ff, ry_ff}),
      .rd_data (dn_rd)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= DimBits'(MaxWidth);
         height_ff    <= DimBits'(MaxHeight);
         radius_ff    <= RadBits'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_WRITE) || (state_ff == S_RWAIT)
                      || (state_ff == S_EMIT);
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + AddrBits'(1);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_data;
               CSR_HEIGHT: height_ff <= csr_data;
               CSR_RADIUS: radius_ff <= csr_data[RadBits-1:0];
               default:    ;
            endcase
         end
      end
   end

   // Item datapath.
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_data.action;
         mval_ff <= req_data.marker_value;
         rx_ff   <= req_data.cell_x;
         ry_ff   <= req_data.cell_y;
         bit_ff  <= 3'd7;
      end
      if (state_ff == S_REDUCE) begin
         // One bit of the modulo reduction per cycle.
         if (16'(rx_ff) >= wsh) rx_ff <= rx_ff - wsh[CoordBits-1:0];
         if (16'(ry_ff) >= hsh) ry_ff <= ry_ff - hsh[CoordBits-1:0];
         bit_ff <= bit_ff - 3'd1;
         dx_ff  <= -rs;
         dy_ff  <= '0;
      end
      if (state_ff == S_FREAD) begin
         fx_ff  <= fx;
         fy_ff  <= fy;
         ex_ff  <= -rs;
         ey_ff  <= '0;
         sum_ff <= '0;
         pv_ff  <= 1'b0;
      end
      if (state_ff == S_FWAIT) begin
         a_ff <= mk_rd;
      end
      if (state_ff == S_NBR) begin
         // Read one neighbour per cycle; its term is added in the cycle after.
         pv_ff   <= 1'b1;
         skip_ff <= (nx == fx_ff) && (ny == fy_ff);
         sum_ff  <= sum_in;
         ex_ff   <= ex_nx;
         ey_ff   <= ey_nx;
      end
      if (state_ff == S_DRAIN) begin
         pv_ff  <= 1'b0;
         quo_ff <= sum_in;
      end
      if (state_ff == S_DIV) begin
         // Division by the disc cell count as a product with its reciprocal.
         quo_ff <= SumBits'(prod[SumBits+RecipBits-1:RecipShift]);
      end
      if (state_ff == S_EMIT) begin
         dx_ff <= dx_nx;
         dy_ff <= dy_nx;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_WRITE: begin
            rsp_ff <= '{focus_x: rx_ff, focus_y: ry_ff, local_density: '0, last: 1'b1};
         end
         S_RWAIT: begin
            rsp_ff <= '{focus_x: rx_ff, focus_y: ry_ff, local_density: dn_rd, last: 1'b1};
         end
         S_EMIT: begin
            rsp_ff <= '{focus_x: fx_ff, focus_y: fy_ff,
                        local_density: quo_ff[MarkerBits-1:0], last: focus_last};
         end
         default: rsp_ff <= rsp_ff;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/tldu_ram.sv @@
module tldu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tldu_checker.sv @@
`include "torus_local_density_update_unit_defines.svh"

module tldu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tldu_pkg::req_type req_data,
   input logic              rsp_valid,
   input tldu_pkg::rsp_type rsp_data
);

   import tldu_pkg::*;

   // The density clearing pass keeps the block busy right after reset.
   `TLDU_ASSERT_ALWAYS(a_busy_after_reset, reset |=> busy, "not busy after reset")

   // A taken item with a real action keeps the block busy in the next cycle.
   `TLDU_ASSERT(a_busy_after_accept, start && !busy && req_data.action != ACT_NONE |=> busy, "idle")

   // A non-final result comes only while the block is busy.
   `TLDU_ASSERT(a_mid_result_busy, rsp_valid && !rsp_data.last |-> busy, "non-final result while idle")

   // The final result of an item is never directly followed by another one.
   `TLDU_ASSERT(a_gap_after_last, rsp_valid && rsp_data.last |=> !rsp_valid, "result after final")

endmodule

bind torus_local_density_update_unit tldu_checker u_tldu_checker (.*);
